// File: rtl/core/cbad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_pkg
// Types and constants shared by the bus address decoder core and its parts.
// ----------------------------------------------------------------------------
package cbad_pkg;

    typedef enum logic [2:0] {
        OP_RD_BYTE  = 3'd0,
        OP_RD_WORD  = 3'd1,
        OP_WR_BYTE  = 3'd2,
        OP_WR_WORD  = 3'd3,
        OP_LOAD_ROM = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ROM_END  = 2'd1,
        ST_UNMAPPED = 2'd2,
        ST_FM       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_SND  = 2'd2,
        TGT_MAIN = 2'd3
    } tgt_t;

    // Decoded access, passed from the decoder to the sequencer.
    typedef struct packed {
        tgt_t    target;
        logic    mem_write;
        logic    is_word;
        status_t status;
        logic    misaligned;
        logic    vstrobe;
        logic    vsel;
    } dec_t;

    localparam logic [23:0] SND_RAM_END = 24'hA02000;
    localparam logic [23:0] FM_LOW      = 24'hA04000;
    localparam logic [23:0] FM_HIGH     = 24'hA05000;
    localparam logic [23:0] PORT_MASK   = 24'hFFFFFC;
    localparam logic [23:0] VDP_DATA    = 24'hC00000;
    localparam logic [23:0] VDP_CTRL    = 24'hC00004;

    // Register select bit of the configuration port (word index 0).
    localparam logic        REG_ROM_BYTES = 1'b0;

endpackage

// File: rtl/core/cbad_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cbad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cbad_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_decode
// Region and operation decode of one bus access.
// ----------------------------------------------------------------------------
module cbad_decode (
    input  logic [2:0]    operation,
    input  logic [23:0]   bus_address,
    input  logic [22:0]   rom_bytes_present,
    output cbad_pkg::dec_t dec
);
    import cbad_pkg::*;

    logic       is_word;
    logic       is_read;
    logic       is_write;
    logic [3:0] region;

    assign is_word  = (operation == OP_RD_WORD) || (operation == OP_WR_WORD);
    assign is_read  = (operation == OP_RD_BYTE) || (operation == OP_RD_WORD);
    assign is_write = (operation == OP_WR_BYTE) || (operation == OP_WR_WORD);
    assign region   = bus_address[23:20];

    always_comb
    begin
        dec            = '0;
        dec.target     = TGT_NONE;
        dec.status     = ST_UNMAPPED;
        dec.is_word    = is_word;
        dec.misaligned = is_word && bus_address[0];

        if (operation == OP_LOAD_ROM)
        begin
            dec.target    = TGT_ROM;
            dec.mem_write = 1'b1;
            dec.status    = ST_OK;
        end
        else if (is_read || is_write)
        begin
            case (region) inside
                [4'h0:4'h3]:
                begin
                    // Only the first byte is checked against the image size.
                    if (is_read)
                    begin
                        if (bus_address >= {1'b0, rom_bytes_present})
                        begin
                            dec.status = ST_ROM_END;
                        end
                        else
                        begin
                            dec.status = ST_OK;
                            dec.target = TGT_ROM;
                        end
                    end
                end
                4'hA:
                begin
                    if (!is_word)
                    begin
                        if (bus_address < SND_RAM_END)
                        begin
                            dec.target    = TGT_SND;
                            dec.mem_write = is_write;
                            dec.status    = ST_OK;
                        end
                        else if (bus_address >= FM_LOW && bus_address < FM_HIGH)
                        begin
                            dec.status = ST_FM;
                        end
                    end
                end
                [4'hC:4'hD]:
                begin
                    if (operation == OP_WR_WORD)
                    begin
                        if ((bus_address & PORT_MASK) == VDP_DATA)
                        begin
                            dec.status  = ST_OK;
                            dec.vstrobe = 1'b1;
                        end
                        else if ((bus_address & PORT_MASK) == VDP_CTRL)
                        begin
                            dec.status  = ST_OK;
                            dec.vstrobe = 1'b1;
                            dec.vsel    = 1'b1;
                        end
                    end
                end
                [4'hE:4'hF]:
                begin
                    dec.target    = TGT_MAIN;
                    dec.mem_write = is_write;
                    dec.status    = ST_OK;
                end
                default:
                begin
                    dec.status = ST_UNMAPPED;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/console_bus_address_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_bus_address_decoder_core
// Decodes 24-bit CPU bus accesses onto ROM, sound RAM, main RAM and the
// video chip ports, one byte of memory traffic per cycle while an access executes.
//
//   channel   signals                                    handshake
//   command   operation, bus_address, write_value        start high, busy low
//   result    read_value, access_status, misaligned,     result_valid, 1 cycle
//             video_port_strobe/select/value
//   config    psel, penable, pwrite, paddr, pwdata       APB, pready always high
//
// A byte or non-memory access goes EXEC0, FINISH, then the result strobe; a
// word access to a store goes EXEC0, EXEC1, FINISH: each byte is one access
// of a single-port RAM. After reset the main and sound RAMs are cleared, one
// entry a cycle, busy high until done; configuration writes are taken.
// The result is shown for exactly one cycle and cannot be stalled.
// ROM_DEPTH must be a power of two; ROM addresses wrap modulo ROM_DEPTH.
// ----------------------------------------------------------------------------
module console_bus_address_decoder_core #(
    parameter int ROM_DEPTH       = 1048576,
    parameter int MAIN_RAM_DEPTH  = 65536,
    parameter int SOUND_RAM_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [23:0] bus_address,
    input  logic [15:0] write_value,

    output logic        result_valid,
    output logic [15:0] read_value,
    output logic [1:0]  access_status,
    output logic        misaligned,
    output logic        video_port_strobe,
    output logic        video_port_select,
    output logic [15:0] video_port_value,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbad_pkg::*;

    localparam int ROM_AW  = $clog2(ROM_DEPTH);
    localparam int MAIN_AW = $clog2(MAIN_RAM_DEPTH);
    localparam int SND_AW  = $clog2(SOUND_RAM_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC0,
        S_EXEC1,
        S_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [MAIN_AW-1:0] clr_cnt_reg;
    logic [22:0]        rom_bytes_reg;

    logic [2:0]         op_reg;
    logic [23:0]        addr_reg;
    logic [15:0]        data_reg;
    logic [7:0]         hi_byte_reg;

    logic               valid_reg;
    logic [15:0]        rvalue_reg;
    logic [1:0]         status_reg;
    logic               misaligned_reg;
    logic               vstrobe_reg;
    logic               vsel_reg;
    logic [15:0]        vvalue_reg;

    dec_t               dec;
    logic               accept;
    logic               exec;
    logic               cfg_write;
    logic [7:0]         rd_byte;
    logic [15:0]        rvalue_next;

    logic               main_we;
    logic               main_re;
    logic [MAIN_AW-1:0] main_addr;
    logic [7:0]         main_wdata;
    logic [7:0]         main_rdata;

    logic               snd_we;
    logic               snd_re;
    logic [SND_AW-1:0]  snd_addr;
    logic [7:0]         snd_wdata;
    logic [7:0]         snd_rdata;

    logic               rom_we;
    logic               rom_re;
    logic [ROM_AW-1:0]  rom_addr;
    logic [7:0]         rom_rdata;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign exec      = (state_reg == S_EXEC0) || (state_reg == S_EXEC1);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ROM_BYTES) ? {9'd0, rom_bytes_reg} : 32'd0;

    cbad_decode u_decode (
        .operation         (op_reg),
        .bus_address       (addr_reg),
        .rom_bytes_present (rom_bytes_reg),
        .dec               (dec)
    );

    // Memory request generation: the second byte of a word sits at the next
    // address, wrapping within the store it belongs to.
    always_comb
    begin
        main_we    = (state_reg == S_CLEAR) ||
                     (exec && dec.target == TGT_MAIN && dec.mem_write);
        main_re    = exec && dec.target == TGT_MAIN && !dec.mem_write;
        main_addr  = addr_reg[MAIN_AW-1:0];
        main_wdata = data_reg[7:0];
        if (state_reg == S_CLEAR)
        begin
            main_addr  = clr_cnt_reg;
            main_wdata = 8'd0;
        end
        else if (state_reg == S_EXEC1)
        begin
            main_addr = addr_reg[MAIN_AW-1:0] + {{(MAIN_AW-1){1'b0}}, 1'b1};
        end
        else if (dec.is_word)
        begin
            main_wdata = data_reg[15:8];
        end

        snd_we    = (state_reg == S_CLEAR) ||
                    (state_reg == S_EXEC0 && dec.target == TGT_SND && dec.mem_write);
        snd_re    = state_reg == S_EXEC0 && dec.target == TGT_SND && !dec.mem_write;
        snd_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg[SND_AW-1:0] : addr_reg[SND_AW-1:0];
        snd_wdata = (state_reg == S_CLEAR) ? 8'd0 : data_reg[7:0];

        rom_we   = state_reg == S_EXEC0 && dec.target == TGT_ROM && dec.mem_write;
        rom_re   = exec && dec.target == TGT_ROM && !dec.mem_write;
        rom_addr = addr_reg[ROM_AW-1:0];
        if (state_reg == S_EXEC1)
        begin
            rom_addr = addr_reg[ROM_AW-1:0] + {{(ROM_AW-1){1'b0}}, 1'b1};
        end
    end

    always_comb
    begin
        case (dec.target)
            TGT_ROM:  rd_byte = rom_rdata;
            TGT_SND:  rd_byte = snd_rdata;
            TGT_MAIN: rd_byte = main_rdata;
            default:  rd_byte = 8'd0;
        endcase

        rvalue_next = 16'd0;
        if (dec.target != TGT_NONE && !dec.mem_write)
        begin
            rvalue_next = dec.is_word ? {hi_byte_reg, rd_byte} : {8'd0, rd_byte};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == {MAIN_AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC0;
                end
            end
            S_EXEC0:
            begin
                state_next = (dec.is_word && dec.target != TGT_NONE) ? S_EXEC1 : S_FINISH;
            end
            S_EXEC1:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rom_bytes_reg <= 23'd0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == S_FINISH);
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + {{(MAIN_AW-1){1'b0}}, 1'b1};
            end
            if (cfg_write && paddr[2] == REG_ROM_BYTES)
            begin
                rom_bytes_reg <= pwdata[22:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            addr_reg <= bus_address;
            data_reg <= write_value;
        end
        if (state_reg == S_EXEC1)
        begin
            // The first byte of a word read arrives while the second is requested.
            hi_byte_reg <= rd_byte;
        end
        if (state_reg == S_FINISH)
        begin
            rvalue_reg     <= rvalue_next;
            status_reg     <= dec.status;
            misaligned_reg <= dec.misaligned;
            vstrobe_reg    <= dec.vstrobe;
            vsel_reg       <= dec.vsel;
            vvalue_reg     <= dec.vstrobe ? data_reg : 16'd0;
        end
    end

    cbad_ram #(
        .WIDTH (8),
        .DEPTH (MAIN_RAM_DEPTH)
    ) u_main_ram (
        .clk   (clk),
        .we    (main_we),
        .re    (main_re),
        .addr  (main_addr),
        .wdata (main_wdata),
        .rdata (main_rdata)
    );

    cbad_ram #(
        .WIDTH (8),
        .DEPTH (SOUND_RAM_DEPTH)
    ) u_snd_ram (
        .clk   (clk),
        .we    (snd_we),
        .re    (snd_re),
        .addr  (snd_addr),
        .wdata (snd_wdata),
        .rdata (snd_rdata)
    );

    cbad_ram #(
        .WIDTH (8),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .re    (rom_re),
        .addr  (rom_addr),
        .wdata (data_reg[7:0]),
        .rdata (rom_rdata)
    );

    assign result_valid      = valid_reg;
    assign read_value        = rvalue_reg;
    assign access_status     = status_reg;
    assign misaligned        = misaligned_reg;
    assign video_port_strobe = vstrobe_reg;
    assign video_port_select = vsel_reg;
    assign video_port_value  = vvalue_reg;

`ifndef SYNTHESIS
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while an access is still in progress");

    // An odd port address still reaches the port; only the status must be clean.
    a_port_served: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && video_port_strobe) |-> (access_status == ST_OK))
        else $error("video port strobe with a failed status");
`endif

endmodule

// File: tb/sv/console_bus_address_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_bus_address_decoder_core_tb
// Self-checking bench for the bus address decoder core. A short table of
// hand-picked accesses covers the region edges and the error codes, and is
// followed by random traffic over several ROM size settings. Every accepted
// command word is run through a behavioural copy of the memory map. Each
// result word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module console_bus_address_decoder_core_tb;

    import cbad_pkg::*;

    localparam int unsigned ROM_DEPTH       = 1048576;
    localparam int unsigned MAIN_RAM_DEPTH  = 65536;
    localparam int unsigned SOUND_RAM_DEPTH = 8192;

    localparam int unsigned ROM_SIZE_MAX    = 4194304;
    localparam logic [23:0] ROM_ADDR_TOP    = 24'h3FFFFF;
    localparam logic [23:0] SND_BASE        = 24'hA00000;
    localparam logic [3:0]  RGN_ROM_LAST    = 4'h3;
    localparam logic [3:0]  RGN_SOUND       = 4'hA;
    localparam logic [3:0]  RGN_SPARE       = 4'hB;
    localparam logic [3:0]  RGN_VIDEO_A     = 4'hC;
    localparam logic [3:0]  RGN_VIDEO_B     = 4'hD;
    localparam logic [3:0]  RGN_RAM_FIRST   = 4'hE;

    // Operation codes beyond the defined set.
    localparam logic [2:0]  OP_RSVD_A       = 3'd5;
    localparam logic [2:0]  OP_RSVD_C       = 3'd7;
    localparam logic [2:0]  OP_RSVD_B       = 3'd6;

    localparam logic [2:0]  ROM_SIZE_ADDR   = {REG_ROM_BYTES, 2'b00};

    localparam int          N_DIRECTED      = 26;
    localparam int          PHASES          = 5;
    localparam int          ITEMS_PER_PHASE = 285;
    localparam int          SETTLE_CYCLES   = 6;
    // Covers the RAM clearing pass after reset with a wide margin.
    localparam int          WATCHDOG_LIMIT  = 400000;

    typedef struct packed {
        logic [15:0] rd;
        status_t     status;
        logic        mis;
        logic        vstrobe;
        logic        vsel;
        logic [15:0] vval;
    } bus_result_t;

    typedef struct {
        bit          reconfig;
        int unsigned rom_size;
        logic [2:0]  op;
        logic [23:0] addr;
        logic [15:0] data;
        bit          typed;
        bus_result_t want;
    } access_row_t;

    localparam bus_result_t NO_RESULT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  operation = '0;
    logic [23:0] bus_address = '0;
    logic [15:0] write_value = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        busy;
    logic        result_valid;
    logic [15:0] read_value;
    logic [1:0]  access_status;
    logic        misaligned;
    logic        video_port_strobe;
    logic        video_port_select;
    logic [15:0] video_port_value;
    logic [31:0] prdata;
    logic        pready;

    // Behavioural copy of the memory map.
    bit [7:0]    main_ram_img [MAIN_RAM_DEPTH];
    bit [7:0]    sound_ram_img [SOUND_RAM_DEPTH];
    bit [7:0]    rom_img [int unsigned];
    int unsigned rom_size;

    bus_result_t pending_results [$];
    int unsigned loaded_rom_idx [$];
    logic [15:0] recent_offsets [$];
    logic [23:0] last_load_addr;
    bit          mismatch_seen;
    int          stall_cycles;

    access_row_t directed_rows [N_DIRECTED];

    console_bus_address_decoder_core #(
        .ROM_DEPTH       (ROM_DEPTH),
        .MAIN_RAM_DEPTH  (MAIN_RAM_DEPTH),
        .SOUND_RAM_DEPTH (SOUND_RAM_DEPTH)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .bus_address       (bus_address),
        .write_value       (write_value),
        .result_valid      (result_valid),
        .read_value        (read_value),
        .access_status     (access_status),
        .misaligned        (misaligned),
        .video_port_strobe (video_port_strobe),
        .video_port_select (video_port_select),
        .video_port_value  (video_port_value),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] rom_byte(input int unsigned a);
        int unsigned idx;
        idx = a % ROM_DEPTH;
        return rom_img.exists(idx) ? rom_img[idx] : 8'h00;
    endfunction

    // Decodes one access against the copy of the map and returns its result word.
    function automatic bus_result_t predict_access(input logic [2:0] op,
                                                   input logic [23:0] a,
                                                   input logic [15:0] d);
        bus_result_t res;
        logic [3:0]  region;
        logic [15:0] i0;
        logic [23:0] port;
        bit          is_word;
        res        = NO_RESULT;
        res.status = ST_UNMAPPED;
        region     = a[23:20];
        is_word    = (op == OP_RD_WORD || op == OP_WR_WORD);
        i0         = a[15:0];
        port       = a & PORT_MASK;
        if (op == OP_LOAD_ROM) begin
            rom_img[a % ROM_DEPTH] = d[7:0];
            res.status = ST_OK;
        end else if (op > OP_LOAD_ROM) begin
            res.status = ST_UNMAPPED;
        end else if (region <= RGN_ROM_LAST) begin
            if (op == OP_RD_BYTE || op == OP_RD_WORD) begin
                if (a >= rom_size) begin
                    res.status = ST_ROM_END;
                end else begin
                    res.status = ST_OK;
                    if (op == OP_RD_BYTE)
                        res.rd = {8'h00, rom_byte(a)};
                    else
                        res.rd = {rom_byte(a), rom_byte(a + 1)};
                end
            end
        end else if (region == RGN_SOUND) begin
            if (!is_word) begin
                if (a < SND_RAM_END) begin
                    res.status = ST_OK;
                    if (op == OP_RD_BYTE)
                        res.rd = {8'h00, sound_ram_img[a[12:0]]};
                    else
                        sound_ram_img[a[12:0]] = d[7:0];
                end else if (a >= FM_LOW && a < FM_HIGH) begin
                    res.status = ST_FM;
                end
            end
        end else if (region == RGN_VIDEO_A || region == RGN_VIDEO_B) begin
            if (op == OP_WR_WORD && (port == VDP_DATA || port == VDP_CTRL)) begin
                res.status  = ST_OK;
                res.vstrobe = 1'b1;
                res.vsel    = (port == VDP_CTRL);
                res.vval    = d;
            end
        end else if (region >= RGN_RAM_FIRST) begin
            res.status = ST_OK;
            // A word at offset 0xFFFF takes its low byte from offset 0.
            case (op)
                OP_RD_BYTE: res.rd = {8'h00, main_ram_img[i0]};
                OP_RD_WORD: res.rd = {main_ram_img[i0], main_ram_img[i0 + 16'd1]};
                OP_WR_BYTE: main_ram_img[i0] = d[7:0];
                default:
                begin
                    main_ram_img[i0]         = d[15:8];
                    main_ram_img[i0 + 16'd1] = d[7:0];
                end
            endcase
        end
        res.mis = is_word && a[0];
        return res;
    endfunction

    // A ROM read may only touch store entries that have been loaded.
    function automatic bit rom_readable(input logic [23:0] a, input bit is_word);
        int unsigned idx;
        idx = a % ROM_DEPTH;
        if (a >= rom_size)
            return 1'b1;
        return rom_img.exists(idx) && (!is_word || rom_img.exists((idx + 1) % ROM_DEPTH));
    endfunction

    task automatic pick_access(output logic [2:0] op, output logic [23:0] addr,
                               output logic [15:0] data);
        int unsigned kind;
        int unsigned bound_addr;
        int unsigned choice;
        logic [15:0] ofs;
        kind = $urandom_range(0, 99);
        op   = 3'($urandom_range(OP_RD_BYTE, OP_WR_WORD));
        addr = 24'($urandom);
        data = 16'($urandom);
        if (recent_offsets.size() != 0 && $urandom_range(0, 1) == 1)
            ofs = recent_offsets[$urandom_range(0, recent_offsets.size() - 1)];
        else
            ofs = 16'($urandom);
        if (kind < 3) begin
            op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
        end else if (kind < 18) begin
            op = OP_LOAD_ROM;
            // Runs of consecutive loads make word reads possible later.
            if ($urandom_range(0, 1) == 1)
                addr = last_load_addr + 24'd1;
        end else if (kind < 40) begin
            addr[23:22] = 2'b00;
            if (op == OP_RD_BYTE || op == OP_RD_WORD) begin
                choice = $urandom_range(0, 3);
                if (choice == 0 && rom_size != 0) begin
                    bound_addr = rom_size - 1 + $urandom_range(0, 1);
                    addr = (bound_addr > ROM_ADDR_TOP) ? ROM_ADDR_TOP : 24'(bound_addr);
                end else if (choice >= 2 && loaded_rom_idx.size() != 0) begin
                    addr = 24'(loaded_rom_idx[$urandom_range(0, loaded_rom_idx.size() - 1)]
                               + $urandom_range(0, 3) * ROM_DEPTH);
                end
                if (!rom_readable(addr, op == OP_RD_WORD)) begin
                    if (loaded_rom_idx.size() == 0) begin
                        op = OP_LOAD_ROM;
                    end else begin
                        addr = 24'(loaded_rom_idx[$urandom_range(0, loaded_rom_idx.size() - 1)]);
                        if (!rom_readable(addr, op == OP_RD_WORD))
                            op = OP_RD_BYTE;
                    end
                end
            end
        end else if (kind < 65) begin
            if ($urandom_range(0, 9) == 0)
                ofs = 16'hFFFF;
            addr = {3'b111, 5'($urandom), ofs};
        end else if (kind < 78) begin
            case ($urandom_range(0, 3))
                0, 1:    addr = SND_BASE | 24'(ofs[12:0]);
                2:       addr = FM_LOW | 24'($urandom_range(0, 12'hFFF));
                default: addr = {RGN_SOUND, addr[19:0]};
            endcase
        end else if (kind < 90) begin
            if ($urandom_range(0, 1) == 1) begin
                addr = VDP_DATA | 24'($urandom_range(0, 7));
                if ($urandom_range(0, 3) != 0)
                    op = OP_WR_WORD;
            end else begin
                addr[23:21] = 3'b110;
            end
        end else begin
            addr[23:20] = 4'($urandom_range(4, 10));
            if (addr[23:20] == RGN_SOUND)
                addr[23:20] = RGN_SPARE;
        end
        if (op == OP_LOAD_ROM) begin
            last_load_addr = addr;
            loaded_rom_idx.push_back(addr % ROM_DEPTH);
        end else if ((op == OP_WR_BYTE || op == OP_WR_WORD) && kind >= 40 && kind < 78) begin
            recent_offsets.push_back(addr[15:0]);
            if (recent_offsets.size() > 32)
                void'(recent_offsets.pop_front());
        end
    endtask

    // Holds the command word until the core takes it; start stays high on return.
    task automatic send_access(input logic [2:0] op, input logic [23:0] addr,
                               input logic [15:0] data, input bit typed,
                               input bus_result_t want);
        bus_result_t res;
        start       <= 1'b1;
        operation   <= op;
        bus_address <= addr;
        write_value <= data;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        res = predict_access(op, addr, data);
        pending_results.push_back(typed ? want : res);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rom_size(input int unsigned size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROM_SIZE_ADDR;
        pwdata  <= 32'(size);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        rom_size = size;
    endtask

    always @(posedge clk) begin
        bus_result_t exp_res;
        if (rst_n && result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result word with no access outstanding");
                mismatch_seen = 1'b1;
            end else begin
                exp_res = pending_results.pop_front();
                if (read_value !== exp_res.rd) begin
                    $error("read_value: expected %h, got %h", exp_res.rd, read_value);
                    mismatch_seen = 1'b1;
                end
                if (access_status !== exp_res.status) begin
                    $error("access_status: expected %0d, got %0d",
                           exp_res.status, access_status);
                    mismatch_seen = 1'b1;
                end
                if (misaligned !== exp_res.mis) begin
                    $error("misaligned: expected %b, got %b", exp_res.mis, misaligned);
                    mismatch_seen = 1'b1;
                end
                if (video_port_strobe !== exp_res.vstrobe) begin
                    $error("video_port_strobe: expected %b, got %b",
                           exp_res.vstrobe, video_port_strobe);
                    mismatch_seen = 1'b1;
                end
                if (video_port_select !== exp_res.vsel) begin
                    $error("video_port_select: expected %b, got %b",
                           exp_res.vsel, video_port_select);
                    mismatch_seen = 1'b1;
                end
                if (video_port_value !== exp_res.vval) begin
                    $error("video_port_value: expected %h, got %h",
                           exp_res.vval, video_port_value);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Counts cycles in which neither a command word nor a result word moves.
    always @(posedge clk) begin
        if ((start && busy === 1'b0) || result_valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned phase_size [PHASES];
        logic [2:0]  op;
        logic [23:0] addr;
        logic [15:0] data;
        stall_cycles   = 0;
        mismatch_seen  = 1'b0;
        rom_size       = 0;
        last_load_addr = '0;
        directed_rows = '{
            '{0, 0, OP_RD_BYTE, 24'h000000, 16'h0000, 1,
              '{16'h0000, ST_ROM_END, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RD_WORD, 24'h3FFFFF, 16'h0000, 1,
              '{16'h0000, ST_ROM_END, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_LOAD_ROM, 24'h000000, 16'hFFA5, 1,
              '{16'h0000, ST_OK, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_LOAD_ROM, 24'h000001, 16'h003C, 1,
              '{16'h0000, ST_OK, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_LOAD_ROM, 24'h3FFFFF, 16'h0081, 1,
              '{16'h0000, ST_OK, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_WR_BYTE, 24'h000010, 16'h1234, 1,
              '{16'h0000, ST_UNMAPPED, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_WR_WORD, 24'h100001, 16'hFFFF, 1,
              '{16'h0000, ST_UNMAPPED, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RD_BYTE, 24'hFF0000, 16'h0000, 1,
              '{16'h0000, ST_OK, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_WR_WORD, 24'hFFFFFF, 16'hBEEF, 1,
              '{16'h0000, ST_OK, 1'b1, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RD_WORD, 24'hE0FFFF, 16'h0000, 0, NO_RESULT},
            '{0, 0, OP_WR_BYTE, 24'hA00000, 16'hFF77, 1,
              '{16'h0000, ST_OK, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_WR_BYTE, 24'hA01FFF, 16'h00FF, 1,
              '{16'h0000, ST_OK, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RD_BYTE, 24'hA01FFF, 16'h0000, 0, NO_RESULT},
            '{0, 0, OP_RD_BYTE, 24'hA02000, 16'h0000, 1,
              '{16'h0000, ST_UNMAPPED, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_WR_BYTE, 24'hA04FFF, 16'h5555, 1,
              '{16'h0000, ST_FM, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RD_WORD, 24'hA00000, 16'h0000, 1,
              '{16'h0000, ST_UNMAPPED, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_WR_WORD, 24'hC00000, 16'hFFFF, 1,
              '{16'h0000, ST_OK, 1'b0, 1'b1, 1'b0, 16'hFFFF}},
            '{0, 0, OP_WR_WORD, 24'hC00007, 16'h8001, 1,
              '{16'h0000, ST_OK, 1'b1, 1'b1, 1'b1, 16'h8001}},
            '{0, 0, OP_WR_WORD, 24'hC00008, 16'h1111, 1,
              '{16'h0000, ST_UNMAPPED, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RD_BYTE, 24'h7FFFFF, 16'h0000, 1,
              '{16'h0000, ST_UNMAPPED, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RSVD_A, 24'hFFFFFF, 16'hFFFF, 1,
              '{16'h0000, ST_UNMAPPED, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RSVD_B, 24'h000000, 16'h00FF, 1,
              '{16'h0000, ST_UNMAPPED, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{0, 0, OP_RSVD_C, 24'hC00004, 16'hFFFF, 1,
              '{16'h0000, ST_UNMAPPED, 1'b0, 1'b0, 1'b0, 16'h0000}},
            '{1, ROM_SIZE_MAX, OP_RD_WORD, 24'h3FFFFF, 16'h0000, 0, NO_RESULT},
            '{1, 2, OP_RD_WORD, 24'h000000, 16'h0000, 0, NO_RESULT},
            '{0, 0, OP_RD_BYTE, 24'h000002, 16'h0000, 1,
              '{16'h0000, ST_ROM_END, 1'b0, 1'b0, 1'b0, 16'h0000}}
        };
        phase_size = '{ROM_SIZE_MAX, 0, $urandom_range(1, ROM_ADDR_TOP),
                       $urandom_range(1, 4096), ROM_SIZE_MAX};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].reconfig) begin
                drain_results();
                write_rom_size(directed_rows[i].rom_size);
            end
            send_access(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                        directed_rows[i].typed, directed_rows[i].want);
        end

        // The size register only changes once the core has gone quiet.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_rom_size(phase_size[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick_access(op, addr, data);
                send_access(op, addr, data, 1'b0, NO_RESULT);
                if (p != PHASES - 1 && $urandom_range(0, 7) == 0)
                    pause_sender($urandom_range(1, 18));
            end
        end

        drain_results();
        if (!mismatch_seen && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
